@@ src/hblm_pkg.sv @@
`default_nettype none

package hblm_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FIELD_W = 16;
	localparam int CHAN_W = 3;
	localparam int FRAC_BITS = 16;
	localparam int WEIGHT_W = 17;
	localparam int LANES = 4;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h10000;
	localparam logic [WEIGHT_W:0] SMOOTH_K = 18'd196608;
	localparam logic [FIELD_W-1:0] MIN_WIDTH = 16'd7;
	localparam logic [FIELD_W-1:0] WIDTH_RESET = 16'd6554;

	localparam logic [CHAN_W-1:0] CH_HEIGHT = 3'd0;
	localparam logic [CHAN_W-1:0] CH_NORMAL = 3'd4;

	localparam logic MODE_HARD = 1'b0;
	localparam logic MODE_SMOOTH = 1'b1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BLEND_MODE = 1'b0,
		REG_TRANSITION_WIDTH = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

@@ src/hblm_in_if.sv @@
`default_nettype none

interface hblm_in_if;
	logic valid;
	logic ready;
	logic [hblm_pkg::CHAN_W-1:0] channel_index;
	logic one_present;
	logic two_present;
	logic [hblm_pkg::FIELD_W-1:0] one_red;
	logic [hblm_pkg::FIELD_W-1:0] one_green;
	logic [hblm_pkg::FIELD_W-1:0] one_blue;
	logic [hblm_pkg::FIELD_W-1:0] one_alpha;
	logic [hblm_pkg::FIELD_W-1:0] two_red;
	logic [hblm_pkg::FIELD_W-1:0] two_green;
	logic [hblm_pkg::FIELD_W-1:0] two_blue;
	logic [hblm_pkg::FIELD_W-1:0] two_alpha;

	modport source (
		output valid, channel_index, one_present, two_present,
		output one_red, one_green, one_blue, one_alpha,
		output two_red, two_green, two_blue, two_alpha,
		input ready
	);

	modport sink (
		input valid, channel_index, one_present, two_present,
		input one_red, one_green, one_blue, one_alpha,
		input two_red, two_green, two_blue, two_alpha,
		output ready
	);
endinterface

`default_nettype wire

@@ src/hblm_out_if.sv @@
`default_nettype none

interface hblm_out_if;
	logic valid;
	logic ready;
	logic [hblm_pkg::CHAN_W-1:0] result_channel;
	logic [hblm_pkg::FIELD_W-1:0] out_red;
	logic [hblm_pkg::FIELD_W-1:0] out_green;
	logic [hblm_pkg::FIELD_W-1:0] out_blue;
	logic [hblm_pkg::FIELD_W-1:0] out_alpha;

	modport source (
		output valid, result_channel, out_red, out_green, out_blue, out_alpha,
		input ready
	);

	modport sink (
		input valid, result_channel, out_red, out_green, out_blue, out_alpha,
		output ready
	);
endinterface

`default_nettype wire

@@ src/hblm_lane.sv @@
`default_nettype none

module hblm_lane #(
	parameter int SAMPLE_BITS = hblm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [SAMPLE_BITS-1:0]            a,
	input  logic [SAMPLE_BITS-1:0]            b,
	input  logic [hblm_pkg::WEIGHT_W-1:0]     weight,
	output logic [SAMPLE_BITS-1:0]            mixed
);

	localparam int FRAC = hblm_pkg::FRAC_BITS;
	localparam int DW = SAMPLE_BITS + 1;
	localparam int MW = DW + hblm_pkg::WEIGHT_W + 1;
	localparam logic signed [MW-1:0] HALF_LSB = MW'(1) <<< (FRAC - 1);
	localparam logic signed [MW-1:0] FULL_W = MW'((2 ** SAMPLE_BITS) - 1);

	logic signed [DW-1:0] diff;
	logic signed [MW-1:0] prod;
	logic signed [MW-1:0] prod_s1;
	logic [SAMPLE_BITS-1:0] a_s1;
	logic signed [MW-1:0] sum;
	logic signed [MW-1:0] scaled;

	// The mix a*(1-w) + b*w is formed as a*2^16 + (b-a)*w.
	assign diff = $signed({1'b0, b}) - $signed({1'b0, a});
	assign prod = diff * $signed({1'b0, weight});

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod;
			a_s1 <= a;
		end
	end

	assign sum = $signed(MW'({a_s1, {FRAC{1'b0}}})) + prod_s1 + HALF_LSB;
	assign scaled = sum >>> FRAC;

	always_comb begin
		priority if (sum[MW-1]) begin
			mixed = '0;
		end else if (scaled > FULL_W) begin
			mixed = {SAMPLE_BITS{1'b1}};
		end else begin
			mixed = scaled[SAMPLE_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

@@ src/hblm_weight.sv @@
`default_nettype none

module hblm_weight #(
	parameter int SAMPLE_BITS = hblm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [SAMPLE_BITS+1:0]             diff,
	input  logic [hblm_pkg::FIELD_W-1:0]       width,
	output logic                               done,
	output logic [hblm_pkg::WEIGHT_W-1:0]      weight
);

	localparam int FRAC = hblm_pkg::FRAC_BITS;
	localparam int WW = hblm_pkg::WEIGHT_W;
	localparam int DW = SAMPLE_BITS + 2;
	localparam int NW = DW + FRAC;
	localparam int RW = WW + 1;
	localparam int CW = $clog2(NW);
	localparam int PRW = WW + RW;
	localparam int PW = PRW + WW;
	localparam logic [PW-1:0] ROUND = PW'(1) << (2 * FRAC - 1);

	typedef enum logic [2:0] {
		W_IDLE,
		W_PREP,
		W_DIV,
		W_CLAMP,
		W_SQ,
		W_HI,
		W_LO,
		W_SUM
	} wstate_t;

	wstate_t state_q;
	logic [CW-1:0] cnt_q;
	logic done_q;
	logic [WW-1:0] weight_q;

	logic [DW-1:0] diff_q;
	logic [RW-1:0] den_q;
	logic [NW-1:0] num_q;
	logic [RW-1:0] rem_q;
	logic [RW-1:0] quo_q;
	logic ovf_q;
	logic [WW-1:0] t_q;
	logic [RW-1:0] m_q;
	logic [WW-1:0] lo_q;
	logic [PRW-1:0] prod_q;
	logic [PRW-1:0] acc_q;

	logic [FRAC-1:0] width_sel;
	logic [RW:0] trial;
	logic fits;
	logic [WW-1:0] mul_a;
	logic [RW-1:0] mul_b;
	logic [PRW-1:0] mul_p;
	logic [PW-1:0] poly;

	assign width_sel = (width < hblm_pkg::MIN_WIDTH) ? hblm_pkg::MIN_WIDTH : width;
	assign trial = {rem_q, num_q[NW-1]};
	assign fits = trial >= {1'b0, den_q};

	always_comb begin
		unique case (state_q)
			W_SQ: begin
				mul_a = t_q;
				mul_b = RW'(t_q);
			end
			W_HI: begin
				mul_a = prod_q[2*WW-1:WW];
				mul_b = m_q;
			end
			default: begin
				mul_a = lo_q;
				mul_b = m_q;
			end
		endcase
	end

	assign mul_p = PRW'(mul_a) * PRW'(mul_b);
	assign poly = {acc_q, {WW{1'b0}}} + PW'(prod_q) + ROUND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= W_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
			weight_q <= '0;
		end else begin
			done_q <= (state_q == W_SUM);
			unique case (state_q)
				W_IDLE: begin
					if (start) begin
						state_q <= W_PREP;
					end
				end
				W_PREP: begin
					cnt_q <= '0;
					state_q <= W_DIV;
				end
				W_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(NW - 1)) begin
						state_q <= W_CLAMP;
					end
				end
				W_CLAMP: state_q <= W_SQ;
				W_SQ: state_q <= W_HI;
				W_HI: state_q <= W_LO;
				W_LO: state_q <= W_SUM;
				W_SUM: begin
					weight_q <= poly[2*FRAC +: WW];
					state_q <= W_IDLE;
				end
				default: state_q <= W_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			W_IDLE: begin
				if (start) begin
					diff_q <= diff;
					den_q <= RW'({width_sel, 1'b0}) + RW'(width_sel);
				end
			end
			W_PREP: begin
				num_q <= {diff_q, {FRAC{1'b0}}} + NW'(den_q >> 1);
				rem_q <= '0;
				quo_q <= '0;
				ovf_q <= 1'b0;
			end
			W_DIV: begin
				rem_q <= fits ? RW'(trial - {1'b0, den_q}) : trial[RW-1:0];
				num_q <= num_q << 1;
				quo_q <= {quo_q[RW-2:0], fits};
				ovf_q <= ovf_q | quo_q[RW-1];
			end
			W_CLAMP: begin
				if (ovf_q || quo_q > {1'b0, hblm_pkg::WEIGHT_ONE}) begin
					t_q <= hblm_pkg::WEIGHT_ONE;
				end else begin
					t_q <= quo_q[WW-1:0];
				end
			end
			W_SQ: begin
				prod_q <= mul_p;
				m_q <= hblm_pkg::SMOOTH_K - {t_q, 1'b0};
			end
			W_HI: begin
				lo_q <= prod_q[WW-1:0];
				prod_q <= mul_p;
			end
			W_LO: begin
				acc_q <= prod_q;
				prod_q <= mul_p;
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign weight = weight_q;

endmodule

`default_nettype wire

@@ src/height_blend_layer_mix.sv @@
// A channel item passes from the accepting beat through S_MIX, where the lanes register their
// products, to S_FIN; a height item in hard mode or with layer two not higher goes through S_GRAY
// and S_HEIGHT to S_FIN, and one that runs the smoothstep divider (one quotient bit per cycle) also waits in S_SMOOTH.
// One item is in work at a time: a new beat is taken only once the block is back in S_IDLE.
// The output register lets the next item start while a result waits to be taken.
// Reset is asynchronous, active low: hard mode, width 6554, blend weight 0, no result pending.
`default_nettype none

module height_blend_layer_mix #(
	parameter int SAMPLE_BITS = hblm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	hblm_in_if.sink                               pixel,
	hblm_out_if.source                            result,
	input  logic                                  cfg_we,
	input  logic [hblm_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [hblm_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int FW = hblm_pkg::FIELD_W;
	localparam int WW = hblm_pkg::WEIGHT_W;
	localparam int LN = hblm_pkg::LANES;
	localparam int SW = SAMPLE_BITS + 2;
	localparam int K = SAMPLE_BITS + 3;
	localparam logic [K-1:0] RECIP = K'((2 ** K + 2) / 3);
	localparam logic [SAMPLE_BITS-1:0] FULL = {SAMPLE_BITS{1'b1}};
	localparam logic [SAMPLE_BITS-1:0] HALF = SAMPLE_BITS'(2 ** (SAMPLE_BITS - 1));

	typedef enum logic [2:0] {
		S_IDLE,
		S_GRAY,
		S_HEIGHT,
		S_SMOOTH,
		S_MIX,
		S_FIN
	} state_t;

	state_t state_q;
	logic out_valid_q;
	logic [hblm_pkg::CHAN_W-1:0] out_ch_q;
	logic [FW-1:0] out_red_q;
	logic [FW-1:0] out_green_q;
	logic [FW-1:0] out_blue_q;
	logic [FW-1:0] out_alpha_q;

	logic mode_q;
	logic [FW-1:0] width_q;
	logic [WW-1:0] weight_q;

	logic [hblm_pkg::CHAN_W-1:0] ch_q;
	logic [SAMPLE_BITS-1:0] a_q [LN];
	logic [SAMPLE_BITS-1:0] b_q [LN];
	logic [SW-1:0] s1_q;
	logic [SW-1:0] s2_q;
	logic [SAMPLE_BITS-1:0] gray_q;

	logic [SAMPLE_BITS-1:0] one_raw [LN];
	logic [SAMPLE_BITS-1:0] two_raw [LN];
	logic [SAMPLE_BITS-1:0] dflt [LN];
	logic [SAMPLE_BITS-1:0] a_in [LN];
	logic [SAMPLE_BITS-1:0] b_in [LN];
	logic [SAMPLE_BITS-1:0] lane_mix [LN];

	logic accept;
	logic two_higher;
	logic [SW-1:0] max_sum;
	logic [SW+K-1:0] gray_prod;
	logic w_start;
	logic w_done;
	logic [WW-1:0] w_value;
	logic load_out;

	assign accept = pixel.valid && pixel.ready;
	assign pixel.ready = (state_q == S_IDLE);

	assign one_raw[0] = pixel.one_red[SAMPLE_BITS-1:0];
	assign one_raw[1] = pixel.one_green[SAMPLE_BITS-1:0];
	assign one_raw[2] = pixel.one_blue[SAMPLE_BITS-1:0];
	assign one_raw[3] = pixel.one_alpha[SAMPLE_BITS-1:0];
	assign two_raw[0] = pixel.two_red[SAMPLE_BITS-1:0];
	assign two_raw[1] = pixel.two_green[SAMPLE_BITS-1:0];
	assign two_raw[2] = pixel.two_blue[SAMPLE_BITS-1:0];
	assign two_raw[3] = pixel.two_alpha[SAMPLE_BITS-1:0];

	// An unconnected layer reads as flat normal on the normal channel and black elsewhere.
	always_comb begin
		if (pixel.channel_index == hblm_pkg::CH_NORMAL) begin
			dflt[0] = HALF;
			dflt[1] = HALF;
			dflt[2] = FULL;
			dflt[3] = FULL;
		end else begin
			dflt[0] = '0;
			dflt[1] = '0;
			dflt[2] = '0;
			dflt[3] = (pixel.channel_index == hblm_pkg::CH_HEIGHT) ? '0 : FULL;
		end
		for (int i = 0; i < LN; i++) begin
			a_in[i] = pixel.one_present ? one_raw[i] : dflt[i];
			b_in[i] = pixel.two_present ? two_raw[i] : dflt[i];
		end
	end

	assign two_higher = s2_q > s1_q;
	assign max_sum = two_higher ? s2_q : s1_q;
	assign gray_prod = (SW+K)'(max_sum + 1'b1) * (SW+K)'(RECIP);
	assign w_start = (state_q == S_HEIGHT) && (mode_q == hblm_pkg::MODE_SMOOTH) && two_higher;
	assign load_out = (state_q == S_FIN) && (!out_valid_q || result.ready);

	hblm_weight #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_weight (
		.clk(clk),
		.arst_n(arst_n),
		.start(w_start),
		.diff(s2_q - s1_q),
		.width(width_q),
		.done(w_done),
		.weight(w_value)
	);

	for (genvar g = 0; g < LN; g++) begin : g_lane
		hblm_lane #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_lane (
			.clk(clk),
			.en(state_q == S_MIX),
			.a(a_q[g]),
			.b(b_q[g]),
			.weight(weight_q),
			.mixed(lane_mix[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= hblm_pkg::MODE_HARD;
			width_q <= hblm_pkg::WIDTH_RESET;
		end else if (cfg_we) begin
			unique case (hblm_pkg::cfg_reg_t'(cfg_index))
				hblm_pkg::REG_BLEND_MODE: mode_q <= cfg_data[0];
				hblm_pkg::REG_TRANSITION_WIDTH: width_q <= cfg_data[FW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q <= pixel.channel_index;
			for (int i = 0; i < LN; i++) begin
				a_q[i] <= a_in[i];
				b_q[i] <= b_in[i];
			end
		end
		if (state_q == S_GRAY) begin
			s1_q <= SW'(a_q[0]) + SW'(a_q[1]) + SW'(a_q[2]);
			s2_q <= SW'(b_q[0]) + SW'(b_q[1]) + SW'(b_q[2]);
		end
		if (state_q == S_HEIGHT) begin
			gray_q <= gray_prod[K +: SAMPLE_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			weight_q <= '0;
			out_valid_q <= 1'b0;
			out_ch_q <= '0;
			out_red_q <= '0;
			out_green_q <= '0;
			out_blue_q <= '0;
			out_alpha_q <= '0;
		end else begin
			if (result.ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (pixel.channel_index == hblm_pkg::CH_HEIGHT) ? S_GRAY : S_MIX;
					end
				end
				S_GRAY: state_q <= S_HEIGHT;
				S_HEIGHT: begin
					priority if (mode_q == hblm_pkg::MODE_HARD) begin
						weight_q <= two_higher ? hblm_pkg::WEIGHT_ONE : '0;
						state_q <= S_FIN;
					end else if (two_higher) begin
						state_q <= S_SMOOTH;
					end else begin
						weight_q <= '0;
						state_q <= S_FIN;
					end
				end
				S_SMOOTH: begin
					if (w_done) begin
						weight_q <= w_value;
						state_q <= S_FIN;
					end
				end
				S_MIX: state_q <= S_FIN;
				S_FIN: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						out_ch_q <= ch_q;
						if (ch_q == hblm_pkg::CH_HEIGHT) begin
							out_red_q <= FW'(gray_q);
							out_green_q <= FW'(gray_q);
							out_blue_q <= FW'(gray_q);
							out_alpha_q <= FW'(FULL);
						end else begin
							out_red_q <= FW'(lane_mix[0]);
							out_green_q <= FW'(lane_mix[1]);
							out_blue_q <= FW'(lane_mix[2]);
							out_alpha_q <= FW'(lane_mix[3]);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid = out_valid_q;
	assign result.result_channel = out_ch_q;
	assign result.out_red = out_red_q;
	assign result.out_green = out_green_q;
	assign result.out_blue = out_blue_q;
	assign result.out_alpha = out_alpha_q;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("item accepted but block stayed idle");

	a_done_in_smooth: assert property (@(posedge clk) disable iff (!arst_n)
		w_done |-> (state_q == S_SMOOTH))
		else $error("weight unit finished outside the smooth wait");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_valid_q && !result.ready) |=> (state_q == S_FIN))
		else $error("pending result overwritten");

	a_weight_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_HEIGHT && state_q != S_SMOOTH) |=> $stable(weight_q))
		else $error("blend weight changed outside a height item");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import hblm_pkg::*;

	localparam logic [CHAN_W-1:0] CH_COLOR = 3'd1;
	localparam logic [CHAN_W-1:0] CH_ORM = 3'd2;
	localparam logic [CHAN_W-1:0] CH_EMISSION = 3'd3;
	localparam logic [CHAN_W-1:0] CH_SPARE_A = 3'd5;
	localparam logic [CHAN_W-1:0] CH_SPARE_B = 3'd6;
	localparam logic [CHAN_W-1:0] CH_SPARE_C = 3'd7;

	localparam logic [FIELD_W-1:0] FULL_SCALE = 16'hFFFF;
	localparam logic [FIELD_W-1:0] HALF_SCALE = 16'h8000;

	localparam int DRAIN_CYCLES = 64;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AFTER = 40;
	localparam int PHASES = 9;
	localparam int PHASE_ITEMS = 142;
	localparam int SPREAD_PHASE = 6;

	localparam logic [CFG_DATA_W-1:0] PHASE_MODE [PHASES] = '{
		CFG_DATA_W'(MODE_HARD), CFG_DATA_W'(MODE_SMOOTH), CFG_DATA_W'(MODE_SMOOTH),
		CFG_DATA_W'(MODE_SMOOTH), CFG_DATA_W'(MODE_SMOOTH), CFG_DATA_W'(MODE_SMOOTH),
		CFG_DATA_W'(MODE_SMOOTH), 16'hFFFE, CFG_DATA_W'(MODE_SMOOTH)
	};
	localparam logic [CFG_DATA_W-1:0] PHASE_WIDTH [PHASES] = '{
		WIDTH_RESET, WIDTH_RESET, MIN_WIDTH, 16'hFFFF, 16'd0, 16'd3, WIDTH_RESET, 16'd300,
		16'd300
	};
	localparam bit PHASE_HOLD [PHASES] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};

	typedef logic [0:3][FIELD_W-1:0] rgba_t;

	typedef struct packed {
		logic [CHAN_W-1:0] chan;
		logic one_on;
		logic two_on;
		rgba_t one;
		rgba_t two;
	} layer_pair_t;

	typedef struct packed {
		logic [CHAN_W-1:0] chan;
		rgba_t px;
	} mix_result_t;

	typedef struct packed {
		layer_pair_t item;
		logic fixed;
		rgba_t want;
	} directed_row_t;

	typedef enum {FLOW_OPEN, FLOW_HALF, FLOW_TIGHT} sink_flow_t;

	localparam directed_row_t DIRECTED [21] = '{
		{CH_COLOR, 1'b1, 1'b1, 64'h0001_0002_0003_0004, 64'hFFFF_FFFF_FFFF_FFFF,
			1'b1, 64'h0001_0002_0003_0004},
		{CH_HEIGHT, 1'b0, 1'b0, 64'hAAAA_5555_1234_FFFF, 64'h8000_7FFF_0001_FFFE,
			1'b1, 64'h0000_0000_0000_FFFF},
		{CH_HEIGHT, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_0000, 64'h0000_0000_0000_FFFF,
			1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
		{CH_EMISSION, 1'b1, 1'b1, 64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
			1'b1, 64'h0000_0000_0000_0000},
		{CH_HEIGHT, 1'b1, 1'b1, 64'h0000_0000_0000_FFFF, 64'hFFFF_FFFF_FFFF_0000,
			1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
		{CH_COLOR, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0000,
			1'b1, 64'h0000_0000_0000_0000},
		{CH_NORMAL, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			1'b1, {HALF_SCALE, HALF_SCALE, FULL_SCALE, FULL_SCALE}},
		{CH_ORM, 1'b1, 1'b0, 64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888,
			1'b1, 64'h0000_0000_0000_FFFF},
		{CH_EMISSION, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1234_5678_9ABC_DEF0,
			1'b1, 64'h1234_5678_9ABC_DEF0},
		{CH_SPARE_A, 1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			1'b1, 64'h0000_0000_0000_FFFF},
		{CH_NORMAL, 1'b1, 1'b0, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000,
			1'b1, {HALF_SCALE, HALF_SCALE, FULL_SCALE, FULL_SCALE}},
		{CH_HEIGHT, 1'b1, 1'b1, 64'h0003_0000_0000_1234, 64'h0000_0000_0003_4321,
			1'b1, 64'h0001_0001_0001_FFFF},
		{CH_SPARE_B, 1'b1, 1'b1, 64'h0102_0304_0506_0708, 64'hFEDC_BA98_7654_3210,
			1'b1, 64'h0102_0304_0506_0708},
		{CH_HEIGHT, 1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0001_0000,
			1'b1, 64'h0000_0000_0000_FFFF},
		{CH_SPARE_C, 1'b1, 1'b1, 64'h0102_0304_0506_0708, 64'h8001_7FFF_0000_FFFF,
			1'b1, 64'h8001_7FFF_0000_FFFF},
		{CH_HEIGHT, 1'b1, 1'b1, 64'h0009_0009_0009_FFFF, 64'h0009_0009_0009_0000,
			1'b1, 64'h0009_0009_0009_FFFF},
		{CH_HEIGHT, 1'b1, 1'b1, 64'h0002_0000_0000_0000, 64'h0000_0000_0000_0000,
			1'b1, 64'h0001_0001_0001_FFFF},
		{CH_HEIGHT, 1'b1, 1'b1, 64'h0000_0000_0000_0000, 64'h0001_0001_0000_0000,
			1'b1, 64'h0001_0001_0001_FFFF},
		{CH_COLOR, 1'b1, 1'b1, 64'h3C5A_9E01_7F80_0C0C, 64'h0F0F_F0F0_A5A5_5A5A,
			1'b0, 64'h0},
		{CH_HEIGHT, 1'b1, 1'b1, 64'h7FFF_8000_4000_C000, 64'h7FFE_8001_4002_3FFF,
			1'b0, 64'h0},
		{CH_NORMAL, 1'b1, 1'b1, 64'h2468_ACE0_1357_9BDF, 64'hFDB9_7531_ECA8_6420,
			1'b0, 64'h0}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	hblm_in_if pixel_bus();
	hblm_out_if result_bus();

	height_blend_layer_mix dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pixel_bus),
		.result(result_bus),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic mix_mode;
	logic [FIELD_W-1:0] ramp_width;
	logic [WEIGHT_W-1:0] mix_weight;
	mix_result_t pending_blends [$];
	string lane_name [4] = '{"red", "green", "blue", "alpha"};

	int mismatches = 0;
	int beats_seen = 0;
	int items_sent = 0;
	int heights_sent = 0;
	int ramp_heights = 0;
	int settings_applied = 0;
	int holds_done = 0;
	int burst_left = 0;
	bit hold_request = 1'b0;

	function automatic rgba_t layer_pixel(logic [CHAN_W-1:0] chan, logic on, rgba_t px);
		if (on)
			return px;
		if (chan == CH_NORMAL)
			return {HALF_SCALE, HALF_SCALE, FULL_SCALE, FULL_SCALE};
		return {16'd0, 16'd0, 16'd0, (chan == CH_HEIGHT) ? 16'd0 : FULL_SCALE};
	endfunction

	function automatic logic [WEIGHT_W-1:0] smooth_ramp(logic [17:0] s1, logic [17:0] s2);
		logic [63:0] w;
		logic [63:0] den;
		logic [63:0] t;
		logic [63:0] p;
		if (s2 <= s1)
			return '0;
		w = (ramp_width < MIN_WIDTH) ? 64'(MIN_WIDTH) : 64'(ramp_width);
		den = 3 * w;
		t = ((64'(s2 - s1) << 16) + den / 2) / den;
		if (t > 64'(WEIGHT_ONE))
			t = 64'(WEIGHT_ONE);
		p = t * t * (64'(SMOOTH_K) - 2 * t);
		return WEIGHT_W'((p + 64'h8000_0000) >> 32);
	endfunction

	function automatic mix_result_t blend_layers(layer_pair_t it);
		mix_result_t r;
		rgba_t a;
		rgba_t b;
		logic [17:0] s1;
		logic [17:0] s2;
		logic [17:0] gray;
		logic [63:0] w;
		logic [63:0] v;
		a = layer_pixel(it.chan, it.one_on, it.one);
		b = layer_pixel(it.chan, it.two_on, it.two);
		r.chan = it.chan;
		if (it.chan == CH_HEIGHT) begin
			s1 = 18'(a[0]) + 18'(a[1]) + 18'(a[2]);
			s2 = 18'(b[0]) + 18'(b[1]) + 18'(b[2]);
			gray = (((s1 > s2) ? s1 : s2) + 18'd1) / 18'd3;
			if (gray > 18'(FULL_SCALE))
				gray = 18'(FULL_SCALE);
			if (mix_mode == MODE_HARD) begin
				mix_weight = (s2 > s1) ? WEIGHT_ONE : '0;
			end else begin
				if (s2 > s1)
					ramp_heights++;
				mix_weight = smooth_ramp(s1, s2);
			end
			r.px = {gray[15:0], gray[15:0], gray[15:0], FULL_SCALE};
			return r;
		end
		w = (mix_weight > WEIGHT_ONE) ? 64'(WEIGHT_ONE) : 64'(mix_weight);
		for (int i = 0; i < 4; i++) begin
			v = 64'(a[i]) * (64'(WEIGHT_ONE) - w) + 64'(b[i]) * w;
			v = (v + 64'd32768) >> 16;
			r.px[i] = (v > 64'(FULL_SCALE)) ? FULL_SCALE : v[15:0];
		end
		return r;
	endfunction

	function automatic logic [FIELD_W-1:0] sample16();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return FULL_SCALE;
			default: return FIELD_W'($urandom);
		endcase
	endfunction

	function automatic logic [FIELD_W-1:0] near16(logic [FIELD_W-1:0] base);
		int span;
		int v;
		span = 1 << $urandom_range(0, 15);
		v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0)
			v = 0;
		if (v > int'(FULL_SCALE))
			v = int'(FULL_SCALE);
		return FIELD_W'(v);
	endfunction

	function automatic layer_pair_t random_pair(logic [CHAN_W-1:0] chan);
		layer_pair_t it;
		bit close;
		it.chan = chan;
		it.one_on = ($urandom_range(0, 7) != 0);
		it.two_on = ($urandom_range(0, 7) != 0);
		close = (chan == CH_HEIGHT) && ($urandom_range(0, 1) == 1);
		for (int i = 0; i < 4; i++) begin
			it.one[i] = sample16();
			it.two[i] = close ? near16(it.one[i]) : sample16();
		end
		return it;
	endfunction

	function automatic void flag_mismatch(string what, logic [FIELD_W-1:0] want,
			logic [FIELD_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch on result beat %0d, %s: expected %h, got %h",
				beats_seen, what, want, got);
	endfunction

	task automatic drive_beat(layer_pair_t it, logic fixed, rgba_t want);
		mix_result_t r;
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			case ($urandom_range(0, 7))
				0, 1: gap = 0;
				2: gap = $urandom_range(9, 48);
				default: gap = $urandom_range(1, 8);
			endcase
			if (gap > 0) begin
				pixel_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pixel_bus.valid <= 1'b1;
		pixel_bus.channel_index <= it.chan;
		pixel_bus.one_present <= it.one_on;
		pixel_bus.two_present <= it.two_on;
		pixel_bus.one_red <= it.one[0];
		pixel_bus.one_green <= it.one[1];
		pixel_bus.one_blue <= it.one[2];
		pixel_bus.one_alpha <= it.one[3];
		pixel_bus.two_red <= it.two[0];
		pixel_bus.two_green <= it.two[1];
		pixel_bus.two_blue <= it.two[2];
		pixel_bus.two_alpha <= it.two[3];
		@(posedge clk);
		while (!pixel_bus.ready)
			@(posedge clk);
		r = blend_layers(it);
		if (fixed)
			r.px = want;
		pending_blends.push_back(r);
		items_sent++;
		if (it.chan == CH_HEIGHT)
			heights_sent++;
	endtask

	task automatic settle();
		pixel_bus.valid <= 1'b0;
		burst_left = 0;
		while (pending_blends.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_BLEND_MODE: mix_mode = data[0];
			REG_TRANSITION_WIDTH: ramp_width = data;
			default: ;
		endcase
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("run timed out");
		$display("height_blend_layer_mix verification failed");
		$finish;
	end

	initial begin
		sink_flow_t flow;
		int flow_left;
		flow = FLOW_OPEN;
		flow_left = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				holds_done++;
				result_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (flow_left == 0) begin
				flow = sink_flow_t'($urandom_range(0, 2));
				flow_left = $urandom_range(16, 160);
			end
			flow_left--;
			case (flow)
				FLOW_OPEN: result_bus.ready <= 1'b1;
				FLOW_HALF: result_bus.ready <= ($urandom_range(0, 1) == 1);
				default: result_bus.ready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		mix_result_t want;
		rgba_t got;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			beats_seen++;
			got = {result_bus.out_red, result_bus.out_green, result_bus.out_blue,
				result_bus.out_alpha};
			if (pending_blends.size() == 0) begin
				flag_mismatch("beat with no result pending", '0, got[0]);
			end else begin
				want = pending_blends.pop_front();
				if (result_bus.result_channel !== want.chan)
					flag_mismatch("channel", FIELD_W'(want.chan),
						FIELD_W'(result_bus.result_channel));
				for (int i = 0; i < 4; i++)
					if (got[i] !== want.px[i])
						flag_mismatch(lane_name[i], want.px[i], got[i]);
			end
		end
	end

	initial begin
		int phase_count;
		bit held;
		logic [CFG_DATA_W-1:0] width_word;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_BLEND_MODE;
		cfg_data <= '0;
		pixel_bus.valid <= 1'b0;
		pixel_bus.channel_index <= '0;
		pixel_bus.one_present <= 1'b0;
		pixel_bus.two_present <= 1'b0;
		pixel_bus.one_red <= '0;
		pixel_bus.one_green <= '0;
		pixel_bus.one_blue <= '0;
		pixel_bus.one_alpha <= '0;
		pixel_bus.two_red <= '0;
		pixel_bus.two_green <= '0;
		pixel_bus.two_blue <= '0;
		pixel_bus.two_alpha <= '0;
		mix_mode = MODE_HARD;
		ramp_width = WIDTH_RESET;
		mix_weight = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			drive_beat(DIRECTED[i].item, DIRECTED[i].fixed, DIRECTED[i].want);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			width_word = (p == SPREAD_PHASE) ?
				CFG_DATA_W'($urandom_range(MIN_WIDTH, FULL_SCALE)) : PHASE_WIDTH[p];
			write_reg(REG_BLEND_MODE, PHASE_MODE[p]);
			write_reg(REG_TRANSITION_WIDTH, width_word);
			settings_applied++;
			phase_count = 0;
			held = 1'b0;
			while (phase_count < PHASE_ITEMS) begin
				if (PHASE_HOLD[p] && !held && phase_count >= HOLD_AFTER) begin
					hold_request = 1'b1;
					held = 1'b1;
				end
				if ($urandom_range(0, 4) != 0) begin
					drive_beat(random_pair(CH_HEIGHT), 1'b0, '0);
					phase_count++;
					for (int c = CH_COLOR; c <= CH_NORMAL; c++)
						if ($urandom_range(0, 7) != 0) begin
							drive_beat(random_pair(CHAN_W'(c)), 1'b0, '0);
							phase_count++;
						end
				end else begin
					drive_beat(random_pair(CHAN_W'($urandom_range(CH_HEIGHT, CH_SPARE_C))),
						1'b0, '0);
					phase_count++;
				end
			end
		end

		settle();
		$display("Sent %0d pixel items, %0d of them height items, %0d through the smoothstep ramp.",
			items_sent, heights_sent, ramp_heights);
		$display("Checked %0d result beats over %0d register settings and %0d long stalls.",
			beats_seen, settings_applied, holds_done);
		if (mismatches == 0 && pending_blends.size() == 0) begin
			$display("height_blend_layer_mix verification clean");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches,
				pending_blends.size());
			$display("height_blend_layer_mix verification failed");
		end
		$finish;
	end
endmodule

@@ sim.f @@
src/hblm_pkg.sv
src/hblm_in_if.sv
src/hblm_out_if.sv
src/hblm_lane.sv
src/hblm_weight.sv
src/height_blend_layer_mix.sv
tb/testbench.sv
